@@ sv/ghqr_pkg.sv @@
// ----------------------------------------------------------------------------
// ghqr_pkg
// Shared constants, beat types and fixed-point helpers for the Givens
// rotation Hessenberg QR update unit.
// ----------------------------------------------------------------------------
package ghqr_pkg;

    localparam int MAX_DIM   = 32;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int RHS_N     = MAX_DIM + 1;
    localparam int RHS_AW    = $clog2(RHS_N);
    localparam int U_DEPTH   = RHS_N * MAX_DIM;
    localparam int U_AW      = $clog2(U_DEPTH);
    localparam int OPND_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int FX_W      = PROD_W - FRAC_BITS;
    localparam int ACC_W     = FX_W + IDX_W + 1;
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int RAD_W     = 2 * DATA_W;
    localparam int DEN_W     = DATA_W + 1;
    localparam int Q_W       = NUM_W;
    localparam int REM_W     = DATA_W + 4;

    localparam logic [1:0] OP_ENTRY = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_SOLVE = 2'd2;

    localparam logic KIND_RESID = 1'b0;
    localparam logic KIND_SOL   = 1'b1;

    localparam logic IT_SQRT = 1'b0;
    localparam logic IT_DIV  = 1'b1;

    localparam logic signed [DATA_W-1:0] D_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] D_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic [1:0]               opcode;
        logic [4:0]               column;
        logic [5:0]               row;
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic [5:0]               count;
    } t_in_item;

    typedef struct packed {
        logic                     kind;
        logic [4:0]               index;
        logic signed [DATA_W-1:0] value_res;
        logic                     last_res;
        logic                     div_fault;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic             mode;
        logic [RAD_W-1:0] rad;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_it_req;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] q;
    } t_it_rsp;

    function automatic logic signed [FX_W-1:0] fx_round(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + (PROD_W'(1) << (FRAC_BITS - 1));
        return t[PROD_W-1:FRAC_BITS];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        if (&v[ACC_W-1:DATA_W-1] || ~|v[ACC_W-1:DATA_W-1]) begin
            return v[DATA_W-1:0];
        end
        return v[ACC_W-1] ? D_MIN : D_MAX;
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] a);
        return a[DATA_W-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic logic signed [DATA_W-1:0] unit_ratio(input logic [Q_W-1:0] q,
                                                            input logic neg);
        logic signed [DATA_W-1:0] v;
        v = (q > Q_W'(FX_ONE)) ? FX_ONE : q[DATA_W-1:0];
        return neg ? -v : v;
    endfunction

    function automatic logic signed [DATA_W-1:0] sol_sat(input logic [Q_W-1:0] q,
                                                         input logic neg);
        logic big;
        big = |q[Q_W-1:DATA_W-1];
        if (neg) begin
            return big ? D_MIN : -q[DATA_W-1:0];
        end
        return big ? D_MAX : q[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] resid_abs(input logic signed [DATA_W-1:0] r);
        if (r == D_MIN) begin
            return D_MAX;
        end
        return r[DATA_W-1] ? -r : r;
    endfunction

endpackage

@@ sv/ghqr_ram.sv @@
// ----------------------------------------------------------------------------
// ghqr_ram
// Simple dual-port synchronous RAM with one write port and one read port
// whose data is registered.
// ----------------------------------------------------------------------------
module ghqr_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ sv/ghqr_iter.sv @@
// ----------------------------------------------------------------------------
// ghqr_iter
// Shared iterative unit: integer square root at two radicand bits per cycle,
// or restoring division at one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ghqr_iter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ghqr_pkg::t_it_req i_req,
    output ghqr_pkg::t_it_rsp o_rsp
);
    import ghqr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic             r_mode;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [Q_W-1:0]   r_q;
    logic [RAD_W-1:0] r_src;
    logic [DEN_W-1:0] r_den;

    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] diff;
    logic             take;

    always_comb begin
        if (r_mode == IT_SQRT) begin
            sh    = {r_rem[REM_W-3:0], r_src[RAD_W-1 -: 2]};
            trial = {r_q[REM_W-3:0], 2'b01};
        end else begin
            sh    = {r_rem[REM_W-2:0], r_src[RAD_W-1]};
            trial = REM_W'(r_den);
        end
        take = (sh >= trial);
        diff = sh - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_mode <= i_req.mode;
                r_rem  <= '0;
                r_q    <= '0;
                r_den  <= i_req.den;
                if (i_req.mode == IT_SQRT) begin
                    r_src <= i_req.rad;
                    r_cnt <= CNT_W'(DATA_W);
                end else begin
                    r_src <= {i_req.num, {(RAD_W-NUM_W){1'b0}}};
                    r_cnt <= CNT_W'(NUM_W);
                end
            end else if (r_busy) begin
                r_rem <= take ? diff : sh;
                r_q   <= {r_q[Q_W-2:0], take};
                r_src <= (r_mode == IT_SQRT) ? (r_src << 2) : (r_src << 1);
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule

@@ sv/givens_hessenberg_qr_update_unit.sv @@
// ----------------------------------------------------------------------------
// givens_hessenberg_qr_update_unit
// Incremental Givens QR least-squares update for GMRES with back substitution.
// ----------------------------------------------------------------------------
// The block works on one beat at a time. A start or a plain column entry beat
// is handled in the idle state. A closing entry of column j applies the j
// stored rotations, then one 32-step square root and two 48-step divisions
// (none when the norm is zero) in the shared iterative unit form the new
// rotation. A solve over n columns uses the single multiplier for the inner
// products and one division per element with a nonzero diagonal. The state
// lives in RAMs with registered read data; the right-hand-side vector is
// cleared by a start beat through valid bits, and no clearing pass is needed
// after reset. Results leave through an output register, so the next beat is
// taken while a result waits.
module givens_hessenberg_qr_update_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ghqr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ghqr_pkg::t_out_item o_out_item
);
    import ghqr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_C_RD0, ST_C_H0, ST_C_RDI, ST_C_LDI, ST_C_WRI, ST_C_RDB, ST_C_LDB,
        ST_NORM, ST_C_SQW, ST_C_DVC, ST_C_DVS, ST_C_ROTA, ST_C_WRA, ST_C_WRZ, ST_C_G0,
        ST_C_G1, ST_C_WRG, ST_C_WRG1, ST_ROT, ST_S_ROW, ST_S_LD, ST_S_RDK, ST_S_MUL,
        ST_S_ACC, ST_S_DIAG, ST_S_DIAGW, ST_S_DIVW, ST_EMIT
    } t_state;

    t_state                   r_state;
    t_state                   r_ret;
    logic [2:0]               r_ph;
    logic [IDX_W-1:0]         r_j;
    logic [IDX_W-1:0]         r_i;
    logic [RHS_AW-1:0]        r_k;
    logic [RHS_AW-1:0]        r_n;
    logic signed [DATA_W-1:0] r_h;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;
    logic signed [DATA_W-1:0] r_c;
    logic signed [DATA_W-1:0] r_s;
    logic [DATA_W-1:0]        r_d;
    logic signed [DATA_W-1:0] r_sum;
    logic                     r_neg;
    logic [RAD_W-1:0]         r_sq;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc_a;
    logic signed [ACC_W-1:0]  r_acc_b;
    logic [RHS_N-1:0]         r_rvalid;
    logic                     r_rhs_ok;
    t_out_item                r_pend;
    t_out_item                r_out;
    logic                     r_out_valid;

    logic                     in_acc;
    logic                     out_take;
    logic                     out_free;
    logic signed [OPND_W-1:0] op_a;
    logic signed [OPND_W-1:0] op_b;
    t_it_req                  it_req;
    t_it_rsp                  it_rsp;

    logic                     u_we;
    logic [U_AW-1:0]          u_waddr;
    logic [DATA_W-1:0]        u_wdata;
    logic [U_AW-1:0]          u_raddr;
    logic [DATA_W-1:0]        u_rd;
    logic                     cs_we;
    logic [IDX_W-1:0]         cs_waddr;
    logic [2*DATA_W-1:0]      cs_wdata;
    logic [IDX_W-1:0]         cs_raddr;
    logic [2*DATA_W-1:0]      cs_rd;
    logic                     rhs_we;
    logic [RHS_AW-1:0]        rhs_waddr;
    logic [DATA_W-1:0]        rhs_wdata;
    logic [RHS_AW-1:0]        rhs_raddr;
    logic [DATA_W-1:0]        rhs_rd;
    logic                     sol_we;
    logic [IDX_W-1:0]         sol_waddr;
    logic [DATA_W-1:0]        sol_wdata;
    logic [IDX_W-1:0]         sol_raddr;
    logic [DATA_W-1:0]        sol_rd;

    logic signed [DATA_W-1:0] u_val;
    logic signed [DATA_W-1:0] rhs_val;
    logic signed [DATA_W-1:0] y_zero;
    logic signed [DATA_W-1:0] y_div;
    logic [RHS_AW-1:0]        cnt_n;
    logic [RHS_AW-1:0]        j_ext;

    function automatic logic [U_AW-1:0] ua(input logic [RHS_AW-1:0] row,
                                           input logic [IDX_W-1:0] col);
        return U_AW'(int'(row) * MAX_DIM + int'(col));
    endfunction

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_take = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign u_val    = $signed(u_rd);
    assign rhs_val  = r_rhs_ok ? $signed(rhs_rd) : '0;
    assign y_zero   = (r_sum > 0) ? D_MAX : ((r_sum < 0) ? D_MIN : '0);
    assign y_div    = sol_sat(it_rsp.q, r_neg);
    assign cnt_n    = (int'(i_in_item.count) > MAX_DIM) ? RHS_AW'(MAX_DIM)
                                                        : RHS_AW'(i_in_item.count);
    assign j_ext    = RHS_AW'(r_j);

    always_comb begin
        u_we      = 1'b0;
        u_waddr   = '0;
        u_wdata   = '0;
        u_raddr   = '0;
        cs_we     = 1'b0;
        cs_waddr  = r_j;
        cs_wdata  = {r_c, r_s};
        cs_raddr  = r_i;
        rhs_we    = 1'b0;
        rhs_waddr = '0;
        rhs_wdata = '0;
        rhs_raddr = '0;
        sol_we    = 1'b0;
        sol_waddr = r_i;
        sol_wdata = '0;
        sol_raddr = r_k[IDX_W-1:0];
        op_a      = '0;
        op_b      = '0;
        it_req    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in_item.opcode == OP_ENTRY && int'(i_in_item.column) < MAX_DIM
                    && i_in_item.row <= 6'(i_in_item.column) + 6'd1) begin
                    u_we    = 1'b1;
                    u_waddr = ua(RHS_AW'(i_in_item.row), IDX_W'(i_in_item.column));
                    u_wdata = i_in_item.value;
                end
                if (in_acc && i_in_item.opcode == OP_START) begin
                    rhs_we    = 1'b1;
                    rhs_waddr = '0;
                    rhs_wdata = i_in_item.value;
                end
            end
            ST_C_RD0: u_raddr = ua('0, r_j);
            ST_C_RDI: u_raddr = ua(RHS_AW'(r_i) + 1'b1, r_j);
            ST_C_WRI: begin
                u_we    = 1'b1;
                u_waddr = ua(RHS_AW'(r_i), r_j);
                u_wdata = sat32(r_acc_a);
            end
            ST_C_RDB: u_raddr = ua(j_ext + 1'b1, r_j);
            ST_NORM: begin
                if (r_ph == 3'd0) begin
                    op_a = {1'b0, mag32(r_x)};
                    op_b = {1'b0, mag32(r_x)};
                end else if (r_ph == 3'd1) begin
                    op_a = {1'b0, mag32(r_y)};
                    op_b = {1'b0, mag32(r_y)};
                end else begin
                    it_req.start = 1'b1;
                    it_req.mode  = IT_SQRT;
                    it_req.rad   = r_sq + r_prod[RAD_W-1:0];
                end
            end
            ST_C_SQW: begin
                if (it_rsp.done && it_rsp.q != '0) begin
                    it_req.start = 1'b1;
                    it_req.mode  = IT_DIV;
                    it_req.num   = {mag32(r_x), {FRAC_BITS{1'b0}}}
                                   + NUM_W'(it_rsp.q[DATA_W-1:1]);
                    it_req.den   = {1'b0, it_rsp.q[DATA_W-1:0]};
                end
            end
            ST_C_DVC: begin
                if (it_rsp.done) begin
                    it_req.start = 1'b1;
                    it_req.mode  = IT_DIV;
                    it_req.num   = {mag32(r_y), {FRAC_BITS{1'b0}}} + NUM_W'(r_d[DATA_W-1:1]);
                    it_req.den   = {1'b0, r_d};
                end
            end
            ST_C_ROTA: cs_we = 1'b1;
            ST_C_WRA: begin
                u_we    = 1'b1;
                u_waddr = ua(j_ext, r_j);
                u_wdata = sat32(r_acc_a);
            end
            ST_C_WRZ: begin
                u_we      = 1'b1;
                u_waddr   = ua(j_ext + 1'b1, r_j);
                u_wdata   = '0;
                rhs_raddr = j_ext;
            end
            ST_C_G0: rhs_raddr = j_ext + 1'b1;
            ST_C_WRG: begin
                rhs_we    = 1'b1;
                rhs_waddr = j_ext;
                rhs_wdata = sat32(r_acc_a);
            end
            ST_C_WRG1: begin
                rhs_we    = 1'b1;
                rhs_waddr = j_ext + 1'b1;
                rhs_wdata = sat32(r_acc_b);
            end
            ST_ROT: begin
                case (r_ph)
                    3'd0: begin
                        op_a = {r_c[DATA_W-1], r_c};
                        op_b = {r_x[DATA_W-1], r_x};
                    end
                    3'd1: begin
                        op_a = {r_s[DATA_W-1], r_s};
                        op_b = {r_y[DATA_W-1], r_y};
                    end
                    3'd2: begin
                        op_a = {r_c[DATA_W-1], r_c};
                        op_b = {r_y[DATA_W-1], r_y};
                    end
                    3'd3: begin
                        op_a = {r_s[DATA_W-1], r_s};
                        op_b = {r_x[DATA_W-1], r_x};
                    end
                    default: begin
                        op_a = '0;
                        op_b = '0;
                    end
                endcase
            end
            ST_S_ROW: rhs_raddr = RHS_AW'(r_i);
            ST_S_RDK: u_raddr = ua(RHS_AW'(r_i), r_k[IDX_W-1:0]);
            ST_S_MUL: begin
                op_a = {u_rd[DATA_W-1], u_rd};
                op_b = {sol_rd[DATA_W-1], sol_rd};
            end
            ST_S_DIAG: u_raddr = ua(RHS_AW'(r_i), r_i);
            ST_S_DIAGW: begin
                if (u_val == '0) begin
                    sol_we    = 1'b1;
                    sol_wdata = y_zero;
                end else begin
                    it_req.start = 1'b1;
                    it_req.mode  = IT_DIV;
                    it_req.num   = {mag32(r_sum), {FRAC_BITS{1'b0}}}
                                   + NUM_W'(mag32(u_val) >> 1);
                    it_req.den   = {1'b0, mag32(u_val)};
                end
            end
            ST_S_DIVW: begin
                if (it_rsp.done) begin
                    sol_we    = 1'b1;
                    sol_wdata = y_div;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= op_a * op_b;
        r_rhs_ok <= r_rvalid[rhs_raddr];
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_IDLE;
            r_ph        <= '0;
            r_rvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_take && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc && i_in_item.opcode == OP_START) begin
                r_rvalid <= RHS_N'(1);
            end else if (rhs_we) begin
                r_rvalid[rhs_waddr] <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_in_item.opcode == OP_ENTRY && int'(i_in_item.column) < MAX_DIM
                            && i_in_item.last) begin
                            r_j     <= IDX_W'(i_in_item.column);
                            r_state <= ST_C_RD0;
                        end else if (i_in_item.opcode == OP_SOLVE && cnt_n != '0) begin
                            r_n     <= cnt_n;
                            r_i     <= IDX_W'(cnt_n - 1'b1);
                            r_state <= ST_S_ROW;
                        end
                    end
                end
                ST_C_RD0: begin
                    r_i     <= '0;
                    r_state <= ST_C_H0;
                end
                ST_C_H0: begin
                    r_h     <= u_val;
                    r_state <= (r_j != '0) ? ST_C_RDI : ST_C_RDB;
                end
                ST_C_RDI: r_state <= ST_C_LDI;
                ST_C_LDI: begin
                    r_x     <= r_h;
                    r_y     <= u_val;
                    r_c     <= cs_rd[2*DATA_W-1:DATA_W];
                    r_s     <= cs_rd[DATA_W-1:0];
                    r_ph    <= '0;
                    r_ret   <= ST_C_WRI;
                    r_state <= ST_ROT;
                end
                ST_C_WRI: begin
                    r_h <= sat32(r_acc_b);
                    if ({1'b0, r_i} + 1'b1 < {1'b0, r_j}) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_C_RDI;
                    end else begin
                        r_state <= ST_C_RDB;
                    end
                end
                ST_C_RDB: r_state <= ST_C_LDB;
                ST_C_LDB: begin
                    r_x     <= r_h;
                    r_y     <= u_val;
                    r_ph    <= '0;
                    r_state <= ST_NORM;
                end
                ST_NORM: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 3'd1) begin
                        r_sq <= r_prod[RAD_W-1:0];
                    end else if (r_ph == 3'd2) begin
                        r_state <= ST_C_SQW;
                    end
                end
                ST_C_SQW: begin
                    if (it_rsp.done) begin
                        r_d <= it_rsp.q[DATA_W-1:0];
                        if (it_rsp.q == '0) begin
                            r_c     <= FX_ONE;
                            r_s     <= '0;
                            r_state <= ST_C_ROTA;
                        end else begin
                            r_state <= ST_C_DVC;
                        end
                    end
                end
                ST_C_DVC: begin
                    if (it_rsp.done) begin
                        r_c     <= unit_ratio(it_rsp.q, r_x[DATA_W-1]);
                        r_state <= ST_C_DVS;
                    end
                end
                ST_C_DVS: begin
                    if (it_rsp.done) begin
                        r_s     <= unit_ratio(it_rsp.q, r_y[DATA_W-1]);
                        r_state <= ST_C_ROTA;
                    end
                end
                ST_C_ROTA: begin
                    r_ph    <= '0;
                    r_ret   <= ST_C_WRA;
                    r_state <= ST_ROT;
                end
                ST_C_WRA: r_state <= ST_C_WRZ;
                ST_C_WRZ: r_state <= ST_C_G0;
                ST_C_G0: begin
                    r_x     <= rhs_val;
                    r_state <= ST_C_G1;
                end
                ST_C_G1: begin
                    r_y     <= rhs_val;
                    r_ph    <= '0;
                    r_ret   <= ST_C_WRG;
                    r_state <= ST_ROT;
                end
                ST_C_WRG: r_state <= ST_C_WRG1;
                ST_C_WRG1: begin
                    r_pend.kind      <= KIND_RESID;
                    r_pend.index     <= 5'(r_j);
                    r_pend.value_res <= resid_abs(sat32(r_acc_b));
                    r_pend.last_res  <= 1'b1;
                    r_pend.div_fault <= 1'b0;
                    r_state          <= ST_EMIT;
                end
                ST_ROT: begin
                    r_ph <= r_ph + 1'b1;
                    case (r_ph)
                        3'd1: r_acc_a <= ACC_W'(fx_round(r_prod));
                        3'd2: r_acc_a <= r_acc_a + ACC_W'(fx_round(r_prod));
                        3'd3: r_acc_b <= ACC_W'(fx_round(r_prod));
                        3'd4: begin
                            r_acc_b <= r_acc_b - ACC_W'(fx_round(r_prod));
                            r_state <= r_ret;
                        end
                        default: begin
                        end
                    endcase
                end
                ST_S_ROW: r_state <= ST_S_LD;
                ST_S_LD: begin
                    r_acc_a <= ACC_W'(rhs_val);
                    r_k     <= RHS_AW'(r_i) + 1'b1;
                    r_state <= (RHS_AW'(r_i) + 1'b1 < r_n) ? ST_S_RDK : ST_S_DIAG;
                end
                ST_S_RDK: r_state <= ST_S_MUL;
                ST_S_MUL: r_state <= ST_S_ACC;
                ST_S_ACC: begin
                    r_acc_a <= r_acc_a - ACC_W'(fx_round(r_prod));
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k + 1'b1 < r_n) ? ST_S_RDK : ST_S_DIAG;
                end
                ST_S_DIAG: begin
                    r_sum   <= sat32(r_acc_a);
                    r_state <= ST_S_DIAGW;
                end
                ST_S_DIAGW: begin
                    r_pend.kind     <= KIND_SOL;
                    r_pend.index    <= 5'(r_i);
                    r_pend.last_res <= (r_i == '0);
                    r_neg           <= r_sum[DATA_W-1] != u_val[DATA_W-1];
                    if (u_val == '0) begin
                        r_pend.value_res <= y_zero;
                        r_pend.div_fault <= 1'b1;
                        r_state          <= ST_EMIT;
                    end else begin
                        r_pend.div_fault <= 1'b0;
                        r_state          <= ST_S_DIVW;
                    end
                end
                ST_S_DIVW: begin
                    if (it_rsp.done) begin
                        r_pend.value_res <= y_div;
                        r_state          <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out       <= r_pend;
                        r_out_valid <= 1'b1;
                        if (r_pend.last_res) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_i     <= r_i - 1'b1;
                            r_state <= ST_S_ROW;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    ghqr_ram #(.DEPTH(U_DEPTH), .WIDTH(DATA_W)) u_upper (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_raddr (u_raddr),
        .o_rdata (u_rd)
    );

    ghqr_ram #(.DEPTH(MAX_DIM), .WIDTH(2 * DATA_W)) u_rotations (
        .i_clk   (i_clk),
        .i_we    (cs_we),
        .i_waddr (cs_waddr),
        .i_wdata (cs_wdata),
        .i_raddr (cs_raddr),
        .o_rdata (cs_rd)
    );

    ghqr_ram #(.DEPTH(RHS_N), .WIDTH(DATA_W)) u_rhs (
        .i_clk   (i_clk),
        .i_we    (rhs_we),
        .i_waddr (rhs_waddr),
        .i_wdata (rhs_wdata),
        .i_raddr (rhs_raddr),
        .o_rdata (rhs_rd)
    );

    ghqr_ram #(.DEPTH(MAX_DIM), .WIDTH(DATA_W)) u_solution (
        .i_clk   (i_clk),
        .i_we    (sol_we),
        .i_waddr (sol_waddr),
        .i_wdata (sol_wdata),
        .i_raddr (sol_raddr),
        .o_rdata (sol_rd)
    );

    ghqr_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (it_req),
        .o_rsp   (it_rsp)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
